// ===== hw/rtl/open_addressing_probe_insert_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the open-addressing probe/insert block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_PROBE_INSERT_DEFINES_SVH
`define OPEN_ADDRESSING_PROBE_INSERT_DEFINES_SVH

// Same-cycle implication.
`define OAPI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("open_addressing_probe_insert: same-cycle check failed");

// Next-cycle implication.
`define OAPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("open_addressing_probe_insert: next-cycle check failed");

`endif

// ===== hw/rtl/oapi_pkg.sv =====
// ----------------------------------------------------------------------------
// Open-addressing probe/insert package
// Word types, field widths, opcodes and controller states.
// ----------------------------------------------------------------------------
package oapi_pkg;

	localparam int SLOT_INDEX_W   = 10;
	localparam int COUNT_W        = 11;
	localparam int KEY_W          = 64;
	localparam int VALUE_W        = 64;
	localparam int CAP_LOG2_W     = 4;
	localparam int CAP_LOG2_MIN   = 3;
	localparam int CAP_LOG2_RESET = 3;
	// Width of the generation tag kept per slot; tag zero always means free.
	localparam int EPOCH_W        = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic [SLOT_INDEX_W-1:0] slot_index;
		logic [COUNT_W-1:0]      occupied_count;
		logic                    table_full;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PROBE
	} ctrl_state_t;

endpackage

// ===== hw/rtl/open_addressing_probe_insert.sv =====
// ----------------------------------------------------------------------------
// Open-addressing probe/insert table
// Linear-probing insert into a power-of-two key/value table with occupancy.
// ----------------------------------------------------------------------------
// An item is taken in the idle state, then the occupancy memory is read once
// per probed slot, one slot a cycle, as the insert steps past occupied slots;
// the step that ends an item waits while a stalled result word holds the
// output register. A clear item or an insert into a full table ends at its
// first probe step. The occupancy memory read is registered. Occupancy is
// kept as a generation tag per slot, so a clear or a capacity write does not
// walk the table; after reset and after every (2**EPOCH_W - 1)th clear or
// capacity write the block runs a clearing pass over all 2**MAX_SLOTS_LOG2
// slots during which it takes no item (configuration writes are still
// taken). A configuration write is not taken while an item is being probed,
// and an item offered together with a write waits behind it. A result word
// waits in an output register, and the next item is taken while it waits.
module open_addressing_probe_insert #(
	parameter int MAX_SLOTS_LOG2 = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  oapi_pkg::req_word_t                 req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output oapi_pkg::rsp_word_t                 rsp_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [oapi_pkg::CAP_LOG2_W-1:0]     cfg_data
);
	import oapi_pkg::*;

	localparam int IDX_W  = MAX_SLOTS_LOG2;
	localparam int DEPTH  = 1 << MAX_SLOTS_LOG2;
	localparam int CNT_W  = MAX_SLOTS_LOG2 + 1;
	localparam int LOG2_W = $clog2(MAX_SLOTS_LOG2 + 1);

	// Control and payload registers.
	ctrl_state_t             state_q, state_nx;
	logic [CAP_LOG2_W-1:0]   cap_log2_q;
	logic [CNT_W-1:0]        count_q;
	logic [EPOCH_W-1:0]      epoch_q;
	logic [IDX_W-1:0]        sweep_q;
	logic [IDX_W-1:0]        idx_q;
	opcode_t                 op_q;
	logic [KEY_W-1:0]        key_q;
	logic [VALUE_W-1:0]      value_q;
	logic                    rsp_valid_q;
	rsp_word_t               rsp_q;

	// Memories: generation tag per slot, and the stored key/value pairs.
	logic [EPOCH_W-1:0]          occ_mem [DEPTH];
	logic [KEY_W+VALUE_W-1:0]    data_mem [DEPTH];
	logic [EPOCH_W-1:0]          occ_rdata;

	// Derived capacity.
	logic [LOG2_W-1:0]       used_log2;
	logic [IDX_W-1:0]        mask;
	logic [CNT_W-1:0]        cap;
	logic [IDX_W-1:0]        home;
	logic [IDX_W-1:0]        idx_next;

	// Controller outputs.
	logic                    req_take;
	logic                    cfg_take;
	logic                    out_free;
	logic                    table_at_cap;
	logic                    slot_free;
	logic                    occ_we;
	logic [IDX_W-1:0]        occ_waddr;
	logic [EPOCH_W-1:0]      occ_wdata;
	logic                    data_we;
	logic [IDX_W-1:0]        rd_addr;
	logic                    load_idx;
	logic                    finish;
	logic                    do_clear;
	logic                    do_insert;
	logic                    sweep_last;
	logic                    epoch_wrap;
	rsp_word_t               rsp_nx;

	always_comb begin
		if (int'(cap_log2_q) > MAX_SLOTS_LOG2) begin
			used_log2 = LOG2_W'(MAX_SLOTS_LOG2);
		end else if (int'(cap_log2_q) < CAP_LOG2_MIN) begin
			used_log2 = LOG2_W'(CAP_LOG2_MIN);
		end else begin
			used_log2 = LOG2_W'(cap_log2_q);
		end
	end

	assign mask         = ~({IDX_W{1'b1}} << used_log2);
	assign cap          = CNT_W'(1) << used_log2;
	assign home         = req_data.key[IDX_W:1] & mask;
	assign idx_next     = (idx_q + IDX_W'(1)) & mask;
	assign table_at_cap = (count_q >= cap);
	assign slot_free    = (occ_rdata != epoch_q);
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign sweep_last   = (sweep_q == {IDX_W{1'b1}});
	assign epoch_wrap   = (epoch_q == {EPOCH_W{1'b1}});

	// A pending configuration write goes ahead of an item.
	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign req_take  = req_valid && !req_stall;
	assign cfg_ready = (state_q != ST_PROBE);
	assign cfg_take  = cfg_valid && cfg_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Controller outputs: memory control and result formation.
	always_comb begin
		occ_we    = 1'b0;
		occ_waddr = idx_q;
		occ_wdata = epoch_q;
		data_we   = 1'b0;
		rd_addr   = idx_q;
		load_idx  = 1'b0;
		finish    = 1'b0;
		do_clear  = 1'b0;
		do_insert = 1'b0;
		rsp_nx    = '0;
		unique case (state_q)
			ST_SWEEP: begin
				occ_we    = 1'b1;
				occ_waddr = sweep_q;
				occ_wdata = '0;
			end
			ST_IDLE: begin
				rd_addr  = home;
				load_idx = req_take;
				do_clear = cfg_take;
			end
			ST_PROBE: begin
				priority if (op_q == OP_CLEAR) begin
					finish   = out_free;
					do_clear = out_free;
				end else if (table_at_cap) begin
					finish                = out_free;
					rsp_nx.occupied_count = COUNT_W'(count_q);
					rsp_nx.table_full     = 1'b1;
				end else if (slot_free) begin
					// Hold the address while the output register is busy.
					finish                = out_free;
					do_insert             = out_free;
					occ_we                = out_free;
					data_we               = out_free;
					rsp_nx.slot_index     = SLOT_INDEX_W'(idx_q);
					rsp_nx.occupied_count = COUNT_W'(count_q + CNT_W'(1));
				end else begin
					rd_addr = idx_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (do_clear && epoch_wrap) begin
					state_nx = ST_SWEEP;
				end else if (req_take) begin
					state_nx = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (do_clear && epoch_wrap) begin
					state_nx = ST_SWEEP;
				end else if (finish) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			cap_log2_q  <= CAP_LOG2_W'(CAP_LOG2_RESET);
			count_q     <= '0;
			epoch_q     <= EPOCH_W'(1);
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_take) begin
				cap_log2_q <= cfg_data;
			end
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
			if (do_clear || cfg_take) begin
				count_q <= '0;
			end else if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (do_clear) begin
				if (epoch_wrap) begin
					epoch_q <= EPOCH_W'(1);
					sweep_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (load_idx) begin
			op_q    <= req_data.opcode;
			key_q   <= req_data.key;
			value_q <= req_data.value;
			idx_q   <= home;
		end else if (state_q == ST_PROBE && !finish && rd_addr != idx_q) begin
			idx_q <= idx_next;
		end
		if (finish) begin
			rsp_q <= rsp_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		occ_rdata <= occ_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[idx_q] <= {key_q, value_q};
		end
	end

`include "open_addressing_probe_insert_defines.svh"

	`OAPI_ASSERT_IMP(a_count_within_cap, state_q != ST_SWEEP, count_q <= cap)
	`OAPI_ASSERT_IMP(a_epoch_nonzero, 1'b1, epoch_q != '0)
	`OAPI_ASSERT_IMP(a_write_in_range, data_we, (idx_q & ~mask) == '0)
	`OAPI_ASSERT_NEXT(a_clear_empties, do_clear, count_q == '0)

endmodule

// ===== bench/probe_insert_checker.sv =====
// ----------------------------------------------------------------------------
// Probe/insert table checker
// Watches the request, result and capacity channels of the open-addressing
// table, keeps its own occupancy map, predicts each result word and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module probe_insert_checker #(
	parameter int MAX_LOG2 = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  oapi_pkg::req_word_t                 req_data,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  oapi_pkg::rsp_word_t                 rsp_data,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [oapi_pkg::CAP_LOG2_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  full_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import oapi_pkg::*;

	bit [(1<<MAX_LOG2)-1:0] occ;
	int unsigned            entries;
	logic [CAP_LOG2_W-1:0]  cap_reg;
	rsp_word_t              expected_words[$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// Walks the occupancy map the way the block should and returns the word
	// that the item must produce.
	task automatic predict_item(input req_word_t w, output rsp_word_t r);
		int unsigned l;
		int unsigned cap;
		int unsigned mask;
		int unsigned idx;
		int unsigned steps;
		bit          found;
		l = 32'(cap_reg);
		if (l < CAP_LOG2_MIN) l = CAP_LOG2_MIN;
		if (l > MAX_LOG2) l = MAX_LOG2;
		cap = 1 << l;
		mask = cap - 1;
		r = '0;
		found = 1'b0;
		if (w.opcode == OP_CLEAR) begin
			occ = '0;
			entries = 0;
			return;
		end
		if (entries < cap) begin
			idx = 32'(w.key >> 1) & mask;
			for (steps = 0; steps < cap && !found; steps++) begin
				if (!occ[idx[MAX_LOG2-1:0]]) found = 1'b1;
				else idx = (idx + 1) & mask;
			end
		end
		if (found) begin
			occ[idx[MAX_LOG2-1:0]] = 1'b1;
			entries++;
			r.slot_index = idx[SLOT_INDEX_W-1:0];
			r.occupied_count = entries[COUNT_W-1:0];
		end else begin
			r.occupied_count = entries[COUNT_W-1:0];
			r.table_full = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		rsp_word_t next_word;
		if (!arst_n) begin
			occ = '0;
			entries = 0;
			cap_reg = CAP_LOG2_W'(CAP_LOG2_RESET);
			expected_words.delete();
			fail_count = 0;
			full_seen = 0;
			pending = 0;
		end else begin
			// A capacity write empties the table just as a clear does.
			if (cfg_valid && cfg_ready) begin
				cap_reg = cfg_data;
				occ = '0;
				entries = 0;
			end
			if (req_valid && !req_stall) begin
				predict_item(req_data, next_word);
				expected_words.push_back(next_word);
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					report("result word with nothing waiting", 64'(rsp_data), 64'(0));
				end else begin
					want = expected_words.pop_front();
					if (rsp_data.slot_index != want.slot_index)
						report("slot_index", 64'(rsp_data.slot_index),
							64'(want.slot_index));
					if (rsp_data.occupied_count != want.occupied_count)
						report("occupied_count", 64'(rsp_data.occupied_count),
							64'(want.occupied_count));
					if (rsp_data.table_full != want.table_full)
						report("table_full", 64'(rsp_data.table_full),
							64'(want.table_full));
					if (want.table_full) full_seen++;
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Probe/insert table testbench
// Drives insert and clear words with random gaps and result stalls, walks
// the capacity register through legal, extreme and out-of-range settings,
// and lets the checker judge every result word.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import oapi_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_word_t             req_data = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_word_t             rsp_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CAP_LOG2_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int full_seen;

	int gap_max = 6;
	bit rsp_quiet = 1'b0;
	bit rsp_taken = 1'b0;
	int stall_hold = 0;
	int n_insert = 0;
	int n_clear = 0;
	int n_cfg = 0;

	int cap_plan[16] = '{10, 3, 0, 15, 4, 5, 11, 6, 7, 2, 8, 9, 1, 12, 13, 14};

	open_addressing_probe_insert uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	probe_insert_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.full_seen  (full_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Each result word gets its own stall length, drawn once the previous
	// word has been taken.
	always @(posedge clk) rsp_taken <= rsp_valid && !rsp_stall;

	always @(negedge clk) begin
		if (rsp_taken) stall_hold = rsp_quiet ? 0 : $urandom_range(0, 6);
		if (stall_hold > 0) begin
			rsp_stall <= 1'b1;
			stall_hold--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic req_word_t insert_word(input logic [63:0] k, input logic [63:0] v);
		req_word_t w;
		w.opcode = OP_INSERT;
		w.key = k;
		w.value = v;
		return w;
	endfunction

	function automatic req_word_t clear_word();
		req_word_t w;
		w.opcode = OP_CLEAR;
		w.key = {$urandom, $urandom};
		w.value = {$urandom, $urandom};
		return w;
	endfunction

	// Keys are often bunched on a few home slots, or just below the top of
	// the table, so that probe runs grow long and wrap around.
	function automatic logic [63:0] draw_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: begin
				k[10:1] = 10'($urandom_range(0, 3));
			end
			1: begin
				k[10:1] = 10'(1023 - $urandom_range(0, 3));
			end
			default: begin
			end
		endcase
		return k;
	endfunction

	// The valid stays high between back-to-back words; it is lowered only when
	// a gap is drawn or when the results are drained.
	task automatic send_item(input req_word_t w);
		int gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= w;
		do @(posedge clk); while (req_stall);
		if (w.opcode == OP_CLEAR) n_clear++;
		else n_insert++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_LOG2_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Reset capacity of eight slots: collisions on bit 0, wrap-around,
		// filling up, inserts into a full table and a clear.
		send_item(insert_word(64'h0, 64'h0));
		send_item(insert_word('1, '1));
		send_item(insert_word(64'h1, {$urandom, $urandom}));
		send_item(insert_word(64'hE, {$urandom, $urandom}));
		repeat (4) send_item(insert_word({$urandom, $urandom}, {$urandom, $urandom}));
		repeat (2) send_item(insert_word(draw_key(), {$urandom, $urandom}));
		send_item(clear_word());
		send_item(insert_word(64'h8000_0000_0000_0000, {$urandom, $urandom}));
		drain();

		// Largest table: top slot and a wrap to slot zero.
		write_capacity(4'd10);
		send_item(insert_word('1, {$urandom, $urandom}));
		send_item(insert_word(64'h7FE, {$urandom, $urandom}));
		send_item(insert_word(64'h2, {$urandom, $urandom}));
		send_item(clear_word());

		foreach (cap_plan[p]) begin
			drain();
			write_capacity(cap_plan[p][CAP_LOG2_W-1:0]);
			gap_max = (p % 4 == 1) ? 0 : 6;
			rsp_quiet = (p % 4 == 2);
			repeat (120) begin
				if ($urandom_range(0, 49) == 0) send_item(clear_word());
				else send_item(insert_word(draw_key(), {$urandom, $urandom}));
				if ($urandom_range(0, 199) == 0) drain();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Sent %0d inserts and %0d clears over %0d capacity writes, out-of-range ones too.",
			n_insert, n_clear, n_cfg);
		$display("%0d inserts were turned away by a full table.", full_seen);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/oapi_pkg.sv
hw/rtl/open_addressing_probe_insert.sv
bench/probe_insert_checker.sv
bench/tb.sv
